// ===== rtl/rrsd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the remote report stick/dial decoder.
// Holds register indexes, link event codes, reset values and the fisheye clip helper.
package rrsd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_RELEASE_DIST = 2'd0;
  localparam logic [1:0] CFG_SQUARE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_FISHEYE_GAIN = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // register reset values
  localparam logic [6:0]  RELEASE_DIST_RST = 7'd5;
  localparam logic [14:0] SQUARE_LIMIT_RST = 15'd8192;
  localparam logic [15:0] FISHEYE_GAIN_RST = 16'd54292;

  // link event codes
  localparam logic [1:0] LINK_NONE  = 2'd0;
  localparam logic [1:0] LINK_ALLOW = 2'd1;
  localparam logic [1:0] LINK_DENY  = 2'd2;

  // unknown remote count after reset, never matches a 4-bit count
  localparam logic [4:0] REMOTE_COUNT_UNKNOWN = 5'h1F;

  // report kind that carries stick, dials and button
  localparam logic [3:0] KIND_STICK = 4'd0;

  // unity in Q30
  localparam logic [31:0] FISH_ONE = 32'h4000_0000;

  // shared multiplier geometry
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // floor(p / 2^30), clip to -128..127, offset by 128
  function automatic logic [7:0] fish_clip(input logic signed [MUL_P_W-1:0] p);
    logic signed [MUL_P_W-31:0] f;
    logic [7:0]                  r;
    f = p[MUL_P_W-1:30];
    if (f > 127) begin
      r = 8'hFF;
    end else if (f < -128) begin
      r = 8'h00;
    end else begin
      r = {~f[7], f[6:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/rrsd_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the remote report decoder: one report per request.
// Valid/ready handshake; no package dependency.
interface rrsd_req_if;
  logic       valid;
  logic       ready;
  logic       report_valid;
  logic [3:0] report_kind;
  logic [1:0] button_bits;
  logic [7:0] stick_x_raw;
  logic [7:0] stick_y_raw;
  logic [7:0] dial_byte_a;
  logic [7:0] dial_byte_b;
  logic [3:0] remote_count;
  logic       rearm_capture;

  modport source (
    output valid, report_valid, report_kind, button_bits, stick_x_raw, stick_y_raw,
           dial_byte_a, dial_byte_b, remote_count, rearm_capture,
    input  ready
  );
  modport sink (
    input  valid, report_valid, report_kind, button_bits, stick_x_raw, stick_y_raw,
           dial_byte_a, dial_byte_b, remote_count, rearm_capture,
    output ready
  );
endinterface

// ===== rtl/rrsd_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the remote report decoder: one result per request.
// Valid/ready handshake; no package dependency.
interface rrsd_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        link_event;
  logic              button_event;
  logic              button_pressed;
  logic              dial_update;
  logic signed [7:0] dial_0;
  logic signed [7:0] dial_1;
  logic signed [7:0] dial_2;
  logic signed [7:0] dial_3;
  logic              stick_valid;
  logic [7:0]        stick_x;
  logic [7:0]        stick_y;

  modport source (
    output valid, link_event, button_event, button_pressed, dial_update,
           dial_0, dial_1, dial_2, dial_3, stick_valid, stick_x, stick_y,
    input  ready
  );
  modport sink (
    input  valid, link_event, button_event, button_pressed, dial_update,
           dial_0, dial_1, dial_2, dial_3, stick_valid, stick_x, stick_y,
    output ready
  );
endinterface

// ===== rtl/remote_report_stick_dial_decoder.sv =====
`timescale 1ns / 1ps
// Remote report stick/dial decoder, top level.
// Channels: req_i (sink) takes one report or count-only update per request;
// rsp_o (source) returns exactly one result per request, in order.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write one register per cycle
// (0 release distance, 1 square limit, 2 fisheye gain); write only while idle.
// Link, dial and button decode plus the stick capture gate are done in the
// accept cycle. A request with a released stick then runs six products through
// one shared 17x33 multiplier (x square, x factor, x shape, y square, y factor,
// y shape), one product per cycle.
// Without stick shaping the sequencer goes from idle straight to its final step;
// with it, it steps through SQX, FX, SX, SQY, FY and SY first. req_i.ready is high
// only while the sequencer is idle, so no new request is taken until it returns there.
// The result sits in an output register; while rsp_o is stalled the sequencer
// waits in its final step and takes no new request, and nothing is lost.
// Reset (rst_ni low, asynchronous) restores register defaults, clears dials
// and squares, releases both stick axes and marks the remote count unknown.
// Depends on rrsd_pkg, rrsd_req_if, rrsd_rsp_if and rrsd_mul.
module remote_report_stick_dial_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rrsd_req_if.sink                          req_i,
  rrsd_rsp_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [rrsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rrsd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rrsd_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQX  = 8'b0000_0010,
    ST_FX   = 8'b0000_0100,
    ST_SX   = 8'b0000_1000,
    ST_SQY  = 8'b0001_0000,
    ST_FY   = 8'b0010_0000,
    ST_SY   = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [6:0]  rel_dist_q;
  logic [14:0] sq_limit_q;
  logic [15:0] gain_q;

  // decoder state
  logic              first_q, first_d;
  logic              cap_x_q, cap_x_d, cap_y_q, cap_y_d;
  logic [7:0]        cap_xv_q, cap_xv_d, cap_yv_q, cap_yv_d;
  logic signed [7:0] dial_q [4];
  logic signed [7:0] dial_d [4];
  logic [14:0]       sqx_q, sqx_d, sqy_q, sqy_d;
  logic [4:0]        last_cnt_q, last_cnt_d;

  // per-request work registers
  logic [1:0]        link_q, link_d;
  logic              btn_ev_q, btn_ev_d, btn_pr_q, btn_pr_d;
  logic              dial_upd_q, dial_upd_d;
  logic              stk_vld_q, stk_vld_d;
  logic signed [7:0] sx_q, sx_d, sy_q, sy_d;
  logic [7:0]        x_res_q, x_res_d;

  // output register
  logic              out_vld_q, out_vld_d;
  logic [1:0]        o_link_q;
  logic              o_btn_ev_q, o_btn_pr_q, o_dial_upd_q, o_stk_vld_q;
  logic signed [7:0] o_dial_q [4];
  logic [7:0]        o_x_q, o_y_q;
  logic              out_load;

  // accept-cycle decode
  logic              req_acc;
  logic              kind0;
  logic              first_eff;
  logic              capture;
  logic [7:0]        hold_x, hold_y;
  logic signed [8:0] dx, dy;
  logic [8:0]        mag_x, mag_y;
  logic              far_x, far_y;
  logic              rel_x, rel_y;

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [31:0]               factor;
  logic [14:0]               sq_clamped;

  assign req_acc   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign kind0     = req_i.report_valid && (req_i.report_kind == KIND_STICK);
  assign first_eff = first_q || req_i.rearm_capture;
  assign capture   = kind0 && (req_i.button_bits[0] || first_eff);

  // capture gate: held value versus raw position
  assign hold_x = capture ? req_i.stick_x_raw : cap_xv_q;
  assign hold_y = capture ? req_i.stick_y_raw : cap_yv_q;
  assign dx     = signed'({1'b0, hold_x}) - signed'({1'b0, req_i.stick_x_raw});
  assign dy     = signed'({1'b0, hold_y}) - signed'({1'b0, req_i.stick_y_raw});
  assign mag_x  = dx[8] ? 9'(-dx) : 9'(dx);
  assign mag_y  = dy[8] ? 9'(-dy) : 9'(dy);
  assign far_x  = mag_x > {2'b00, rel_dist_q};
  assign far_y  = mag_y > {2'b00, rel_dist_q};
  assign rel_x  = !((capture || cap_x_q) && !far_x);
  assign rel_y  = !((capture || cap_y_q) && !far_y);

  // Q30 factor and clamped square from the last product
  assign factor     = FISH_ONE + mul_p[31:0];
  assign sq_clamped = (mul_p[14:0] > sq_limit_q) ? sq_limit_q : mul_p[14:0];

  assign out_load = (state_q == ST_FIN) && (!out_vld_q || rsp_o.ready);

  // sequencer and datapath next state
  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    cap_x_d    = cap_x_q;
    cap_y_d    = cap_y_q;
    cap_xv_d   = cap_xv_q;
    cap_yv_d   = cap_yv_q;
    dial_d     = dial_q;
    sqx_d      = sqx_q;
    sqy_d      = sqy_q;
    last_cnt_d = last_cnt_q;
    link_d     = link_q;
    btn_ev_d   = btn_ev_q;
    btn_pr_d   = btn_pr_q;
    dial_upd_d = dial_upd_q;
    stk_vld_d  = stk_vld_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    x_res_d    = x_res_q;
    mul_en     = 1'b1;
    mul_a      = '0;
    mul_b      = '0;

    unique case (state_q)
      ST_IDLE: begin
        mul_en = 1'b0;
        if (req_acc) begin
          first_d = first_eff && !kind0;
          if ({1'b0, req_i.remote_count} != last_cnt_q) begin
            link_d     = (req_i.remote_count != 4'd0) ? LINK_ALLOW : LINK_DENY;
            last_cnt_d = {1'b0, req_i.remote_count};
          end else begin
            link_d = LINK_NONE;
          end
          btn_ev_d   = kind0 && req_i.button_bits[1];
          btn_pr_d   = kind0 && req_i.button_bits[1] && req_i.button_bits[0];
          dial_upd_d = kind0 && ((req_i.dial_byte_a != 8'd0) || (req_i.dial_byte_b != 8'd0));
          stk_vld_d  = kind0 && rel_x && rel_y;
          sx_d       = signed'({~req_i.stick_x_raw[7], req_i.stick_x_raw[6:0]});
          sy_d       = signed'({~req_i.stick_y_raw[7], req_i.stick_y_raw[6:0]});
          if (kind0) begin
            dial_d[0] = dial_q[0] + {{4{req_i.dial_byte_a[3]}}, req_i.dial_byte_a[3:0]};
            dial_d[1] = dial_q[1] + {{4{req_i.dial_byte_a[7]}}, req_i.dial_byte_a[7:4]};
            dial_d[2] = dial_q[2] + {{4{req_i.dial_byte_b[7]}}, req_i.dial_byte_b[7:4]};
            dial_d[3] = dial_q[3] + {{4{req_i.dial_byte_b[3]}}, req_i.dial_byte_b[3:0]};
            cap_x_d   = !rel_x;
            cap_y_d   = !rel_y;
            cap_xv_d  = hold_x;
            cap_yv_d  = hold_y;
          end
          state_d = (kind0 && rel_x && rel_y) ? ST_SQX : ST_FIN;
        end
      end
      ST_SQX: begin
        mul_a   = MUL_A_W'(sx_q);
        mul_b   = MUL_B_W'(sx_q);
        state_d = ST_FX;
      end
      ST_FX: begin
        sqx_d   = sq_clamped;
        mul_a   = signed'(MUL_A_W'(sqy_q));
        mul_b   = signed'(MUL_B_W'(gain_q));
        state_d = ST_SX;
      end
      ST_SX: begin
        mul_a   = MUL_A_W'(sx_q);
        mul_b   = signed'({1'b0, factor});
        state_d = ST_SQY;
      end
      ST_SQY: begin
        x_res_d = fish_clip(mul_p);
        mul_a   = MUL_A_W'(sy_q);
        mul_b   = MUL_B_W'(sy_q);
        state_d = ST_FY;
      end
      ST_FY: begin
        sqy_d   = sq_clamped;
        mul_a   = signed'(MUL_A_W'(sqx_q));
        mul_b   = signed'(MUL_B_W'(gain_q));
        state_d = ST_SY;
      end
      ST_SY: begin
        mul_a   = MUL_A_W'(sy_q);
        mul_b   = signed'({1'b0, factor});
        state_d = ST_FIN;
      end
      ST_FIN: begin
        mul_en = 1'b0;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        mul_en  = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  rrsd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_dist_q <= RELEASE_DIST_RST;
      sq_limit_q <= SQUARE_LIMIT_RST;
      gain_q     <= FISHEYE_GAIN_RST;
    end else if (cfg_we_i) begin
      priority case (cfg_idx_i)
        CFG_RELEASE_DIST: rel_dist_q <= cfg_data_i[6:0];
        CFG_SQUARE_LIMIT: sq_limit_q <= cfg_data_i[14:0];
        CFG_FISHEYE_GAIN: gain_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      first_q    <= 1'b1;
      cap_x_q    <= 1'b0;
      cap_y_q    <= 1'b0;
      dial_q     <= '{default: '0};
      sqx_q      <= '0;
      sqy_q      <= '0;
      last_cnt_q <= REMOTE_COUNT_UNKNOWN;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      first_q    <= first_d;
      cap_x_q    <= cap_x_d;
      cap_y_q    <= cap_y_d;
      dial_q     <= dial_d;
      sqx_q      <= sqx_d;
      sqy_q      <= sqy_d;
      last_cnt_q <= last_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cap_xv_q   <= cap_xv_d;
    cap_yv_q   <= cap_yv_d;
    link_q     <= link_d;
    btn_ev_q   <= btn_ev_d;
    btn_pr_q   <= btn_pr_d;
    dial_upd_q <= dial_upd_d;
    stk_vld_q  <= stk_vld_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    x_res_q    <= x_res_d;
    if (out_load) begin
      o_link_q     <= link_q;
      o_btn_ev_q   <= btn_ev_q;
      o_btn_pr_q   <= btn_pr_q;
      o_dial_upd_q <= dial_upd_q;
      o_stk_vld_q  <= stk_vld_q;
      o_dial_q     <= dial_q;
      o_x_q        <= stk_vld_q ? x_res_q : 8'd0;
      o_y_q        <= stk_vld_q ? fish_clip(mul_p) : 8'd0;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.link_event     = o_link_q;
  assign rsp_o.button_event   = o_btn_ev_q;
  assign rsp_o.button_pressed = o_btn_pr_q;
  assign rsp_o.dial_update    = o_dial_upd_q;
  assign rsp_o.dial_0         = o_dial_q[0];
  assign rsp_o.dial_1         = o_dial_q[1];
  assign rsp_o.dial_2         = o_dial_q[2];
  assign rsp_o.dial_3         = o_dial_q[3];
  assign rsp_o.stick_valid    = o_stk_vld_q;
  assign rsp_o.stick_x        = o_x_q;
  assign rsp_o.stick_y        = o_y_q;

`ifndef SYNTH
  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("request accepted while sequencer busy");

  // a changed remote count always yields a link event
  a_link_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && ({1'b0, req_i.remote_count} != last_cnt_q) |=> link_q != LINK_NONE)
    else $error("remote count change without link event");

  // a shaped stick only comes with a released stick
  a_stick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.stick_valid |-> rsp_o.stick_x == 8'd0 && rsp_o.stick_y == 8'd0)
    else $error("stick value without stick_valid");

  // pressed state only travels with a button event
  a_press_with_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.button_pressed |-> rsp_o.button_event)
    else $error("button_pressed without button_event");

  // the shaping sequence only starts for a released stick
  a_shape_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQX |-> stk_vld_q && !cap_x_q && !cap_y_q)
    else $error("stick shaping started while an axis is captured");
`endif

endmodule

// ===== rtl/rrsd_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product and a load enable.
// Depends on rrsd_pkg for operand widths.
module rrsd_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [rrsd_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [rrsd_pkg::MUL_B_W-1:0] b_i,
  output logic signed [rrsd_pkg::MUL_P_W-1:0] p_o
);
  import rrsd_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // product register, holds while the sequencer is not stepping
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule
